// File: hdl/longest_common_substring_dp_core_macros.svh
// Assertion macros for the longest common substring core.
// Depends on nothing; the including module supplies clk and rst_n.
`ifndef LONGEST_COMMON_SUBSTRING_DP_CORE_MACROS_SVH
`define LONGEST_COMMON_SUBSTRING_DP_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LCS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/lcs_pkg.sv
// Shared types and constants for the longest common substring core.
// Has no dependencies; used by the channel interfaces and the top level.
package lcs_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_LOAD    = 2'd1,
    CMD_PROCESS = 2'd2,
    CMD_REPORT  = 2'd3
  } cmd_t;

  localparam int SYM_W   = 21;
  localparam int POS_W   = 10;
  localparam int LEN_W   = 11;
  localparam int TOTAL_W = 16;
  localparam int CFG_W   = 32;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

endpackage

// File: hdl/lcs_in_if.sv
// Request channel of the longest common substring core.
// Depends on lcs_pkg for the field widths.
interface lcs_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   command;
  logic [lcs_pkg::SYM_W-1:0]    symbol;

  modport source (output valid, command, symbol, input ready);
  modport sink   (input valid, command, symbol, output ready);
endinterface

// File: hdl/lcs_out_if.sv
// Result channel of the longest common substring core.
// Depends on lcs_pkg for the field widths.
interface lcs_out_if;
  logic                          valid;
  logic                          ready;
  logic                          hit_valid;
  logic [lcs_pkg::POS_W-1:0]     first_position;
  logic [lcs_pkg::POS_W-1:0]     second_position;
  logic [lcs_pkg::LEN_W-1:0]     match_length;
  logic [lcs_pkg::TOTAL_W-1:0]   hit_total;
  logic                          truncated;
  logic                          length_overflow;
  logic                          last;

  modport source (output valid, hit_valid, first_position, second_position, match_length,
                  hit_total, truncated, length_overflow, last, input ready);
  modport sink   (input valid, hit_valid, first_position, second_position, match_length,
                  hit_total, truncated, length_overflow, last, output ready);
endinterface

// File: hdl/longest_common_substring_dp_core.sv
// Longest common substring engine, one-row dynamic programming over on-chip memories.
// Depends on lcs_pkg, lcs_in_if, lcs_out_if and longest_common_substring_dp_core_macros.svh.
//
// Usage: requests arrive on in_ch (command, symbol). Clear resets the job, load appends a
// second-string symbol, process sweeps one first-string symbol across the stored string,
// and report streams the kept hits on out_ch, the final one marked by last, or a single
// empty result when nothing was found. min_length is written over the APB-style port at
// address 0 and takes effect at the next clear; pready is always high.
// Clear and load complete when accepted. A process request holds the input off while it
// sweeps the stored string, and completes when accepted if the second string is empty:
// the row memory gives one read-modify-write per cycle. A report reads each hit in
// S_RPT_RD and presents it in S_RPT_OUT before it reads the following hit.
// Requests are taken only while the sequencer is idle; a finished result waits in the
// output register, and a stalled receiver holds a report at the current hit without loss.
// After reset the job is empty and min_length is one; no memory clearing pass is needed,
// as each row entry is written with zero when its symbol is loaded.
module longest_common_substring_dp_core #(
  parameter int MAX_LEN  = 1024,
  parameter int MAX_HITS = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  lcs_in_if.sink                    in_ch,
  lcs_out_if.source                 out_ch,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [lcs_pkg::CFG_W-1:0] pwdata,
  output logic [lcs_pkg::CFG_W-1:0] prdata,
  output logic                      pready
);

  `include "longest_common_substring_dp_core_macros.svh"

  localparam int LW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int BW = ((CW > lcs_pkg::LEN_W) ? CW : lcs_pkg::LEN_W) + 1;
  localparam int SW = (CW > lcs_pkg::POS_W) ? CW : lcs_pkg::POS_W;
  localparam int HW = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
  localparam int HP = 2 * lcs_pkg::POS_W;

  typedef enum logic [1:0] {S_IDLE, S_PROC, S_RPT_RD, S_RPT_OUT} state_t;

  state_t                       state_r;
  logic [lcs_pkg::LEN_W-1:0]    min_len_r;
  logic [CW-1:0]                sec_len_r;
  logic [CW-1:0]                first_idx_r;
  logic signed [BW-1:0]         best_r;
  logic [lcs_pkg::TOTAL_W-1:0]  hit_cnt_r;
  logic                         ovf_r;
  logic [CW-1:0]                rd_j_r;
  logic [LW-1:0]                j_d_r;
  logic                         vld_d_r;
  logic [CW-1:0]                diag_r;
  logic [lcs_pkg::SYM_W-1:0]    sym_r;
  logic [HW-1:0]                k_r;
  logic                         empty_r;

  logic [lcs_pkg::SYM_W-1:0]    sec_mem [MAX_LEN];
  logic [CW-1:0]                row_mem [MAX_LEN];
  logic [HP-1:0]                hit_mem [MAX_HITS];
  logic [lcs_pkg::SYM_W-1:0]    s_q;
  logic [CW-1:0]                p_q;
  logic [HP-1:0]                hit_q;

  logic                  accept, load_ok, cfg_wr;
  lcs_pkg::cmd_t         cmd;
  logic                  match;
  logic [CW-1:0]         run;
  logic signed [BW-1:0]  run_s;
  logic                  gt, eq;
  logic                  hit_we;
  logic [HW-1:0]         hit_wa;
  logic [SW-1:0]         row_start, col_start;
  logic                  row_we;
  logic [LW-1:0]         row_wa;
  logic [CW-1:0]         row_wd;
  logic [HW:0]           kept;
  logic                  rpt_last;
  logic                  out_load;

  assign cmd    = lcs_pkg::cmd_t'(in_ch.command);
  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign load_ok = accept && (cmd == lcs_pkg::CMD_LOAD) && (sec_len_r < CW'(MAX_LEN));
  assign cfg_wr  = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign pready  = 1'b1;
  assign prdata  = (paddr[2] == 1'b0) ? lcs_pkg::CFG_W'(min_len_r) : '0;

  // Diagonal neighbour is the old row entry of the previous column, held in diag_r.
  assign match = vld_d_r && (s_q == sym_r);
  assign run   = match ? CW'(diag_r + 1'b1) : '0;
  assign run_s = $signed(BW'(run));
  assign gt    = match && (run_s > best_r);
  assign eq    = match && (run_s == best_r) && (hit_cnt_r != '0);
  assign hit_we = gt || (eq && (hit_cnt_r < lcs_pkg::TOTAL_W'(MAX_HITS)));
  assign hit_wa = gt ? '0 : hit_cnt_r[HW-1:0];
  assign row_start = SW'(CW'(first_idx_r + 1'b1)) - SW'(run);
  assign col_start = SW'(j_d_r) + SW'(1) - SW'(run);

  always_comb begin
    if (state_r == S_PROC) begin
      row_we = vld_d_r;
      row_wa = j_d_r;
      row_wd = run;
    end else begin
      row_we = load_ok;
      row_wa = sec_len_r[LW-1:0];
      row_wd = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok) begin
      sec_mem[sec_len_r[LW-1:0]] <= in_ch.symbol;
    end
    s_q <= sec_mem[rd_j_r[LW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[row_wa] <= row_wd;
    end
    p_q <= row_mem[rd_j_r[LW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (hit_we) begin
      hit_mem[hit_wa] <= {row_start[lcs_pkg::POS_W-1:0], col_start[lcs_pkg::POS_W-1:0]};
    end
    hit_q <= hit_mem[k_r];
  end

  assign kept = (hit_cnt_r < lcs_pkg::TOTAL_W'(MAX_HITS)) ? hit_cnt_r[HW:0]
                                                          : (HW+1)'(MAX_HITS);
  assign rpt_last = empty_r || ((HW+1)'(k_r) + 1'b1 == kept);
  assign out_load = (state_r == S_RPT_OUT) && (!out_ch.valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      min_len_r   <= lcs_pkg::LEN_W'(1);
      sec_len_r   <= '0;
      first_idx_r <= '0;
      best_r      <= '0;
      hit_cnt_r   <= '0;
      ovf_r       <= 1'b0;
      rd_j_r      <= '0;
      j_d_r       <= '0;
      vld_d_r     <= 1'b0;
      diag_r      <= '0;
      k_r         <= '0;
      empty_r     <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      if (cfg_wr) begin
        min_len_r <= pwdata[lcs_pkg::LEN_W-1:0];
      end
      if (out_load) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            case (cmd)
              lcs_pkg::CMD_CLEAR: begin
                sec_len_r   <= '0;
                first_idx_r <= '0;
                best_r      <= $signed(BW'(min_len_r)) - BW'(1);
                hit_cnt_r   <= '0;
                ovf_r       <= 1'b0;
              end
              lcs_pkg::CMD_LOAD: begin
                if (load_ok) begin
                  sec_len_r <= sec_len_r + 1'b1;
                end else begin
                  ovf_r <= 1'b1;
                end
              end
              lcs_pkg::CMD_PROCESS: begin
                if (first_idx_r >= CW'(MAX_LEN)) begin
                  ovf_r <= 1'b1;
                end else if (sec_len_r == '0) begin
                  first_idx_r <= first_idx_r + 1'b1;
                end else begin
                  state_r <= S_PROC;
                  rd_j_r  <= '0;
                  vld_d_r <= 1'b0;
                  diag_r  <= '0;
                  sym_r   <= in_ch.symbol;
                end
              end
              lcs_pkg::CMD_REPORT: begin
                k_r     <= '0;
                empty_r <= (hit_cnt_r == '0);
                state_r <= (hit_cnt_r == '0) ? S_RPT_OUT : S_RPT_RD;
              end
              default: ;
            endcase
          end
        end
        S_PROC: begin
          // The read pointer has reached sec_len_r by the last column, so the
          // pipeline empties here without a further write.
          if (rd_j_r < sec_len_r) begin
            rd_j_r  <= rd_j_r + 1'b1;
            j_d_r   <= rd_j_r[LW-1:0];
            vld_d_r <= 1'b1;
          end else begin
            vld_d_r <= 1'b0;
          end
          if (vld_d_r) begin
            diag_r <= p_q;
            if (gt) begin
              best_r    <= run_s;
              hit_cnt_r <= lcs_pkg::TOTAL_W'(1);
            end else if (eq && (hit_cnt_r != lcs_pkg::TOTAL_MAX)) begin
              hit_cnt_r <= hit_cnt_r + 1'b1;
            end
            if (CW'(j_d_r) == sec_len_r - 1'b1) begin
              first_idx_r <= first_idx_r + 1'b1;
              state_r     <= S_IDLE;
            end
          end
        end
        S_RPT_RD: begin
          state_r <= S_RPT_OUT;
        end
        S_RPT_OUT: begin
          if (out_load) begin
            if (rpt_last) begin
              state_r <= S_IDLE;
            end else begin
              k_r     <= k_r + 1'b1;
              state_r <= S_RPT_RD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Result payload; only loaded while a report is being streamed.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch.hit_valid       <= !empty_r;
      out_ch.first_position  <= empty_r ? '0 : hit_q[HP-1:lcs_pkg::POS_W];
      out_ch.second_position <= empty_r ? '0 : hit_q[lcs_pkg::POS_W-1:0];
      out_ch.match_length    <= empty_r ? '0 : best_r[lcs_pkg::LEN_W-1:0];
      out_ch.hit_total       <= hit_cnt_r;
      out_ch.truncated       <= (hit_cnt_r > lcs_pkg::TOTAL_W'(MAX_HITS));
      out_ch.length_overflow <= ovf_r;
      out_ch.last            <= rpt_last;
    end
  end

  `LCS_ASSERT_IMPL(a_best_positive, hit_cnt_r != '0, best_r > 0,
                   "hits recorded with a non-positive best length")
  `LCS_ASSERT_IMPL(a_sweep_bound, state_r == S_PROC, rd_j_r <= sec_len_r,
                   "row sweep ran past the stored string")
  `LCS_ASSERT_IMPL(a_write_bound, (state_r == S_PROC) && vld_d_r,
                   CW'(j_d_r) < sec_len_r, "row write outside the stored string")
  `LCS_ASSERT_NEXT(a_sweep_frozen, state_r == S_PROC, $stable(sec_len_r),
                   "string length changed during a sweep")

endmodule
